// ----- src/open_addressing_count_table_assert.svh -----
// Assertion macros used by the checker file oact_chk.sv.
`ifndef OPEN_ADDRESSING_COUNT_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_COUNT_TABLE_ASSERT_SVH

// Same-cycle implication, quiet while in reset.
`define OACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while in reset.
`define OACT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/oact_pkg.sv -----
package oact_pkg;

  localparam int KEY_W  = 63;
  localparam int CNT_W  = 31;
  localparam int SIZE_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_INC  = 2'd0;
  localparam logic [1:0] OP_QRY  = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd1;

  localparam logic [1:0] PM_LINEAR = 2'd0;
  localparam logic [1:0] PM_QUAD   = 2'd1;
  localparam logic [1:0] PM_DOUBLE = 2'd2;
  localparam logic [1:0] PM_UNUSED = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4091;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd3;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              status;
    logic [SIZE_W-1:0] distinct_keys;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } slot_t;

endpackage

// ----- src/open_addressing_count_table.sv -----
// Open-addressing count table. Each input item (increment, query or clear
// plus a 63-bit key) gives exactly one result item: the key's count, a full
// flag and the number of distinct keys stored. Slots live in one
// synchronous memory of MAX_SLOTS entries with one read and one write port;
// s = table_size clamped to 3..MAX_SLOTS slots are used, home = key mod s,
// double-hash step = 1 + key mod (s-1). An increment or query is accepted,
// then the two remainders are formed in 16 steps of four key bits and
// taken, then each probe reads the slot memory and then compares and
// writes back, and finally the result is loaded into the output register.
// A clear sweeps the whole memory, then loads the output register. After
// reset the same sweep runs over the whole memory before in_ready rises;
// config writes are taken throughout. A new item may be accepted while the
// last result still waits.
module open_addressing_count_table
  import oact_pkg::*;
#(
  parameter int MAX_SLOTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_SLOTS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // config
  logic [1:0]        probe_mode_r;
  logic [SIZE_W-1:0] table_size_r;
  logic [SIZE_W-1:0] s_use;

  // control and item state
  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              clr_emit_r, clr_emit_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0] home_r, home_nxt, step_r, step_nxt, slot_r, slot_nxt;
  logic [SIZE_W-1:0] t_r, t_nxt, sq_r, sq_nxt, odd_r, odd_nxt;
  logic [SIZE_W-1:0] distinct_r, distinct_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // slot memory
  slot_t             mem [MAX_SLOTS];
  slot_t             rd_r, mem_wd;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  // remainder unit
  logic              mod_start, mod_done;
  logic [SIZE_W-1:0] rem_s, rem_s1;

  oact_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .key     (in_data.key),
    .divisor (s_use),
    .done    (mod_done),
    .rem_s   (rem_s),
    .rem_s1  (rem_s1)
  );

  always_comb begin
    if (table_size_r < SIZE_MIN) begin
      s_use = SIZE_MIN;
    end else if (32'(table_size_r) > MAX_SLOTS) begin
      s_use = SIZE_W'(MAX_SLOTS);
    end else begin
      s_use = table_size_r;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r <= PM_LINEAR;
      table_size_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PROBE_MODE) begin
        probe_mode_r <= cfg_data[1:0];
      end else if (cfg_index == CFG_TABLE_SIZE) begin
        table_size_r <= cfg_data;
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    logic [SIZE_W:0]   sum, sqs;
    logic [SIZE_W-1:0] tn, sq_new, next_slot;
    logic              hit;
    logic [CNT_W-1:0]  cnt;

    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_emit_nxt   = clr_emit_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    step_nxt       = step_r;
    slot_nxt       = slot_r;
    t_nxt          = t_r;
    sq_nxt         = sq_r;
    odd_nxt        = odd_r;
    distinct_nxt   = distinct_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_wa         = AW'(slot_r);
    mem_wd         = '0;
    mod_start      = 1'b0;

    // next probe position
    tn     = t_r + SIZE_W'(1);
    sq_new = sq_r;
    sum    = '0;
    sqs    = '0;
    unique case (probe_mode_r)
      PM_QUAD: begin
        if (tn[0]) begin
          sqs = {1'b0, sq_r} + {1'b0, odd_r};
          if (sqs >= {1'b0, s_use}) begin
            sqs = sqs - {1'b0, s_use};
          end
          sq_new = sqs[SIZE_W-1:0];
          sum    = {1'b0, home_r} + {1'b0, sq_new};
        end else begin
          sum = {1'b0, home_r} + {1'b0, s_use} - {1'b0, sq_r};
        end
      end
      PM_DOUBLE: sum = {1'b0, slot_r} + {1'b0, step_r};
      default:   sum = {1'b0, slot_r} + (SIZE_W+1)'(1);
    endcase
    if (sum >= {1'b0, s_use}) begin
      sum = sum - {1'b0, s_use};
    end
    next_slot = sum[SIZE_W-1:0];

    hit = !rd_r.used || (rd_r.key == key_r);
    cnt = (rd_r.count == COUNT_MAX) ? rd_r.count : rd_r.count + CNT_W'(1);

    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = '0;
        if (clr_addr_r == AW'(MAX_SLOTS - 1)) begin
          distinct_nxt = '0;
          if (clr_emit_r) begin
            res_count_nxt  = '0;
            res_status_nxt = 1'b0;
            state_nxt      = ST_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          key_nxt = in_data.key;
          priority if (in_data.opcode == OP_INC || in_data.opcode == OP_QRY) begin
            mod_start = 1'b1;
            state_nxt = ST_HASH;
          end else if (in_data.opcode == OP_CLR) begin
            clr_addr_nxt = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = ST_CLR;
          end else begin
            // unused opcode: empty result
            res_count_nxt  = '0;
            res_status_nxt = 1'b0;
            state_nxt      = ST_OUT;
          end
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          home_nxt  = rem_s;
          step_nxt  = rem_s1 + SIZE_W'(1);
          slot_nxt  = rem_s;
          t_nxt     = '0;
          sq_nxt    = '0;
          odd_nxt   = SIZE_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        res_status_nxt = 1'b0;
        if (hit) begin
          if (op_r == OP_INC) begin
            mem_we = 1'b1;
            if (rd_r.used) begin
              mem_wd        = '{used: 1'b1, key: key_r, count: cnt};
              res_count_nxt = cnt;
            end else begin
              mem_wd        = '{used: 1'b1, key: key_r, count: CNT_W'(1)};
              res_count_nxt = CNT_W'(1);
              distinct_nxt  = distinct_r + SIZE_W'(1);
            end
          end else begin
            res_count_nxt = rd_r.used ? rd_r.count : '0;
          end
          state_nxt = ST_OUT;
        end else if (tn == s_use) begin
          // every probe taken without a hit: key absent, full flag set for an increment
          res_count_nxt  = '0;
          res_status_nxt = (op_r == OP_INC);
          state_nxt      = ST_OUT;
        end else begin
          t_nxt    = tn;
          slot_nxt = next_slot;
          sq_nxt   = sq_new;
          if (probe_mode_r == PM_QUAD && tn[0]) begin
            odd_nxt = odd_r + SIZE_W'(2);
          end
          state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{count: res_count_r, status: res_status_r,
                            distinct_keys: distinct_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[AW'(slot_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      clr_emit_r  <= 1'b0;
      distinct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      distinct_r  <= distinct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    step_r       <= step_nxt;
    slot_r       <= slot_nxt;
    t_r          <= t_nxt;
    sq_r         <= sq_nxt;
    odd_r        <= odd_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/oact_mod.sv -----
// Key remainders by s and by s-1, four key bits a cycle.
module oact_mod
  import oact_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] rem_s,
  output logic [SIZE_W-1:0] rem_s1
);

  localparam int SH_W = 64;
  localparam int BITS_PER_CYC = 4;

  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [SIZE_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    logic [SIZE_W:0]   ta, tb;
    logic [SIZE_W-1:0] ra, rb, d1;
    ra = ra_r;
    rb = rb_r;
    d1 = divisor - SIZE_W'(1);
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      ta = {ra, sh_r[SH_W-1-k]};
      tb = {rb, sh_r[SH_W-1-k]};
      if (ta >= {1'b0, divisor}) begin
        ta = ta - {1'b0, divisor};
      end
      if (tb >= {1'b0, d1}) begin
        tb = tb - {1'b0, d1};
      end
      ra = ta[SIZE_W-1:0];
      rb = tb[SIZE_W-1:0];
    end
    sh_nxt   = sh_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = {1'b0, key};
      ra_nxt   = '0;
      rb_nxt   = '0;
      cnt_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = sh_r << BITS_PER_CYC;
      ra_nxt  = ra;
      rb_nxt  = rb;
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
  end

  assign done   = done_r;
  assign rem_s  = ra_r;
  assign rem_s1 = rb_r;

endmodule

// ----- src/oact_chk.sv -----
`include "open_addressing_count_table_assert.svh"

module oact_chk
  import oact_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `OACT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item dropped or changed while stalled")
  `OACT_ASSERT_IMP(a_full_zero, out_valid && out_data.status, out_data.count == '0, "refused increment carries a count")
  `OACT_ASSERT_IMP(a_rst_quiet, $past(!rst_n), !out_valid, "result item straight after reset")

endmodule

bind open_addressing_count_table oact_chk u_oact_chk (.*);
